// ----- rtl/dollar_star_frame_parser_unit_macros.svh -----
// assertion macros shared by the frame parser checker
`ifndef DOLLAR_STAR_FRAME_PARSER_UNIT_MACROS_SVH
`define DOLLAR_STAR_FRAME_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DSFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// next-cycle implication, checked outside reset
`define DSFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

// ----- rtl/dsfp_pkg.sv -----
// types and constants of the dollar star frame parser
`timescale 1ns / 1ps
package dsfp_pkg;

  localparam int TYPE_MAX_DEF    = 6;
  localparam int PAYLOAD_MAX_DEF = 100;

  // fixed result field widths
  localparam int TYPE_CHARS_W = 48;
  localparam int TYPE_SLOTS   = TYPE_CHARS_W / 8;
  localparam int TYPE_LEN_W   = 3;
  localparam int PAY_LEN_W    = 7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic                    message_done;
    logic                    frame_error;
    logic [TYPE_CHARS_W-1:0] type_chars;
    logic [TYPE_LEN_W-1:0]   type_length;
    logic [PAY_LEN_W-1:0]    payload_length;
    logic [7:0]              payload_byte;
    logic                    payload_byte_valid;
    logic [PAY_LEN_W-1:0]    payload_index;
  } res_t;

endpackage

// ----- rtl/dsfp_in_stage.sv -----
// input register of the frame parser
`timescale 1ns / 1ps
module dsfp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       valid_r,
  output logic [7:0] byte_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ----- rtl/dsfp_parse.sv -----
// parse state and per-byte result logic
`timescale 1ns / 1ps
module dsfp_parse import dsfp_pkg::*; #(
  parameter int TYPE_MAX    = TYPE_MAX_DEF,
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  localparam int TCNT_W = $clog2(TYPE_MAX + 1);
  localparam int PCNT_W = $clog2(PAYLOAD_MAX + 1);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        type_store_r [TYPE_MAX];
  logic [7:0]        type_store_nxt [TYPE_MAX];
  logic [TCNT_W-1:0] type_cnt_r, type_cnt_nxt;
  logic [PCNT_W-1:0] pay_cnt_r, pay_cnt_nxt;
  logic              type_full, pay_full;

  assign type_full = (type_cnt_r >= TCNT_W'(TYPE_MAX));
  assign pay_full  = (pay_cnt_r >= PCNT_W'(PAYLOAD_MAX));

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_TYPE: begin
        if (rx_byte == CH_COMMA) begin
          phase_nxt = PH_PAYLOAD;
        end else if (type_full || rx_byte == CH_STAR) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_STAR || pay_full) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = (rx_byte == CH_DOLLAR) ? PH_TYPE : PH_HUNT;
      end
    endcase
  end

  // data path and result fields
  always_comb begin
    type_store_nxt = type_store_r;
    type_cnt_nxt   = type_cnt_r;
    pay_cnt_nxt    = pay_cnt_r;
    res            = '0;
    case (phase_r)
      PH_TYPE: begin
        if (rx_byte == CH_COMMA) begin
          pay_cnt_nxt = '0;
        end else if (type_full) begin
          res.frame_error = 1'b1;
          type_cnt_nxt    = '0;
        end else if (rx_byte == CH_STAR) begin
          res.message_done = 1'b1;
        end else begin
          for (int i = 0; i < TYPE_MAX; i++) begin
            if (type_cnt_r == TCNT_W'(i)) begin
              type_store_nxt[i] = rx_byte;
            end
          end
          type_cnt_nxt = type_cnt_r + 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_STAR) begin
          res.message_done   = 1'b1;
          res.payload_length = PAY_LEN_W'(pay_cnt_r);
        end else if (pay_full) begin
          res.frame_error = 1'b1;
          pay_cnt_nxt     = '0;
        end else begin
          res.payload_byte       = rx_byte;
          res.payload_byte_valid = 1'b1;
          res.payload_index      = PAY_LEN_W'(pay_cnt_r);
          pay_cnt_nxt            = pay_cnt_r + 1'b1;
        end
      end
      default: begin
        if (rx_byte == CH_DOLLAR) begin
          type_cnt_nxt = '0;
          for (int i = 0; i < TYPE_MAX; i++) begin
            type_store_nxt[i] = '0;
          end
        end
      end
    endcase
    // packed view after this byte; entries past the port width drop out
    for (int i = 0; i < TYPE_MAX && i < TYPE_SLOTS; i++) begin
      res.type_chars[8*i +: 8] = type_store_nxt[i];
    end
    res.type_length = TYPE_LEN_W'(type_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      type_cnt_r <= '0;
      pay_cnt_r  <= '0;
      for (int i = 0; i < TYPE_MAX; i++) begin
        type_store_r[i] <= '0;
      end
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      type_cnt_r   <= type_cnt_nxt;
      pay_cnt_r    <= pay_cnt_nxt;
      type_store_r <= type_store_nxt;
    end
  end

endmodule

// ----- rtl/dollar_star_frame_parser_unit.sv -----
// an accepted input item passes the input register, then the result register, to its result item on out_*
// throughput: one item per cycle; the input register and result register
//   move together, so a stall on out_ holds both stages in place
// every byte yields exactly one result item
// reset: rst_n synchronous active low; parser back to hunt, type store and
//   counts zero, both stages empty
`timescale 1ns / 1ps
module dollar_star_frame_parser_unit import dsfp_pkg::*; #(
  parameter int TYPE_MAX    = TYPE_MAX_DEF,
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_message_done,
  output logic                    out_frame_error,
  output logic [TYPE_CHARS_W-1:0] out_type_chars,
  output logic [TYPE_LEN_W-1:0]   out_type_length,
  output logic [PAY_LEN_W-1:0]    out_payload_length,
  output logic [7:0]              out_payload_byte,
  output logic                    out_payload_byte_valid,
  output logic [PAY_LEN_W-1:0]    out_payload_index
);

  // pipeline moves whenever the result slot is empty or being taken
  logic       advance;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  res_t       res;
  res_t       res_r;
  logic       out_valid_r;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // stage one: capture the received byte
  dsfp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_rx_byte(in_rx_byte),
    .valid_r   (in_valid_r),
    .byte_r    (in_byte_r)
  );

  // stage two: phase, type store and counters step once per held byte
  dsfp_parse #(
    .TYPE_MAX   (TYPE_MAX),
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance && in_valid_r),
    .rx_byte(in_byte_r),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_message_done       = res_r.message_done;
  assign out_frame_error        = res_r.frame_error;
  assign out_type_chars         = res_r.type_chars;
  assign out_type_length        = res_r.type_length;
  assign out_payload_length     = res_r.payload_length;
  assign out_payload_byte       = res_r.payload_byte;
  assign out_payload_byte_valid = res_r.payload_byte_valid;
  assign out_payload_index      = res_r.payload_index;

endmodule

// ----- rtl/dsfp_checker.sv -----
// port-level checks of the frame parser, bound to the top level
`timescale 1ns / 1ps
`include "dollar_star_frame_parser_unit_macros.svh"
module dsfp_checker import dsfp_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_message_done,
  input logic                    out_frame_error,
  input logic [TYPE_CHARS_W-1:0] out_type_chars,
  input logic [TYPE_LEN_W-1:0]   out_type_length,
  input logic [PAY_LEN_W-1:0]    out_payload_length,
  input logic [7:0]              out_payload_byte,
  input logic                    out_payload_byte_valid,
  input logic [PAY_LEN_W-1:0]    out_payload_index
);

  // a completion is never also an abort or a payload byte
  `DSFP_ASSERT_NOW(a_done_excl, out_valid && out_message_done, !out_frame_error && !out_payload_byte_valid)
  // an abort never carries a payload byte
  `DSFP_ASSERT_NOW(a_err_excl, out_valid && out_frame_error, !out_payload_byte_valid)
  // length only reported on completion, byte fields zero when unused
  `DSFP_ASSERT_NOW(a_zero_fields, out_valid && !out_message_done && !out_payload_byte_valid, out_payload_length == 0 && out_payload_byte == 0 && out_payload_index == 0)
  // a stalled result holds
  `DSFP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_type_chars) && $stable(out_type_length) && $stable(out_payload_index))

endmodule

bind dollar_star_frame_parser_unit dsfp_checker u_dsfp_checker (.*);

// ----- tb/dsfp_result_check.sv -----
// result checker for the frame parser: predicts one result per byte and compares
`timescale 1ns / 1ps
module dsfp_result_check import dsfp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_message_done,
  input  logic                    out_frame_error,
  input  logic [TYPE_CHARS_W-1:0] out_type_chars,
  input  logic [TYPE_LEN_W-1:0]   out_type_length,
  input  logic [PAY_LEN_W-1:0]    out_payload_length,
  input  logic [7:0]              out_payload_byte,
  input  logic                    out_payload_byte_valid,
  input  logic [PAY_LEN_W-1:0]    out_payload_index,
  output int unsigned             mismatches,
  output int unsigned             pending,
  output int unsigned             frames_done,
  output int unsigned             frames_aborted,
  output int unsigned             payload_seen
);

  // parser state as predicted
  phase_t      phase;
  logic [7:0]  type_bytes [TYPE_SLOTS];
  int unsigned type_cnt;
  int unsigned pay_cnt;
  res_t        parse_results_q [$];

  function automatic res_t predict_result(input logic [7:0] b);
    res_t r;
    r = '0;
    case (phase)
      PH_TYPE: begin
        if (b == CH_COMMA) begin
          phase = PH_PAYLOAD;
          pay_cnt = 0;
        end else if (type_cnt >= TYPE_MAX_DEF) begin
          // seventh type char, star included
          r.frame_error = 1'b1;
          phase = PH_HUNT;
          type_cnt = 0;
        end else if (b == CH_STAR) begin
          r.message_done = 1'b1;
          phase = PH_HUNT;
        end else begin
          type_bytes[type_cnt] = b;
          type_cnt++;
        end
      end
      PH_PAYLOAD: begin
        if (b == CH_STAR) begin
          r.message_done = 1'b1;
          r.payload_length = pay_cnt[PAY_LEN_W-1:0];
          phase = PH_HUNT;
        end else if (pay_cnt >= PAYLOAD_MAX_DEF) begin
          r.frame_error = 1'b1;
          phase = PH_HUNT;
          pay_cnt = 0;
        end else begin
          r.payload_byte = b;
          r.payload_byte_valid = 1'b1;
          r.payload_index = pay_cnt[PAY_LEN_W-1:0];
          pay_cnt++;
        end
      end
      default: begin
        phase = PH_HUNT;
        if (b == CH_DOLLAR) begin
          phase = PH_TYPE;
          type_cnt = 0;
          foreach (type_bytes[i]) type_bytes[i] = 8'h00;
        end
      end
    endcase
    foreach (type_bytes[i]) r.type_chars[8*i +: 8] = type_bytes[i];
    r.type_length = type_cnt[TYPE_LEN_W-1:0];
    return r;
  endfunction

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    mismatches++;
    $display("%0t: %s expected %0h got %0h", $time, name, want, got);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      phase = PH_HUNT;
      foreach (type_bytes[i]) type_bytes[i] = 8'h00;
      type_cnt = 0;
      pay_cnt = 0;
      parse_results_q.delete();
    end else begin
      if (in_valid && !in_stall)
        parse_results_q.push_back(predict_result(in_rx_byte));
      if (out_valid && !out_stall) begin
        got = {out_message_done, out_frame_error, out_type_chars, out_type_length,
               out_payload_length, out_payload_byte, out_payload_byte_valid,
               out_payload_index};
        if (parse_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none got %h", $time, got);
        end else begin
          want = parse_results_q.pop_front();
          if (got.message_done !== want.message_done)
            report_field("message_done", want.message_done, got.message_done);
          if (got.frame_error !== want.frame_error)
            report_field("frame_error", want.frame_error, got.frame_error);
          if (got.type_chars !== want.type_chars)
            report_field("type_chars", want.type_chars, got.type_chars);
          if (got.type_length !== want.type_length)
            report_field("type_length", want.type_length, got.type_length);
          if (got.payload_length !== want.payload_length)
            report_field("payload_length", want.payload_length, got.payload_length);
          if (got.payload_byte !== want.payload_byte)
            report_field("payload_byte", want.payload_byte, got.payload_byte);
          if (got.payload_byte_valid !== want.payload_byte_valid)
            report_field("payload_byte_valid", want.payload_byte_valid,
                         got.payload_byte_valid);
          if (got.payload_index !== want.payload_index)
            report_field("payload_index", want.payload_index, got.payload_index);
          frames_done += want.message_done;
          frames_aborted += want.frame_error;
          payload_seen += want.payload_byte_valid;
        end
      end
    end
    pending = parse_results_q.size();
  end

endmodule

// ----- tb/dollar_star_frame_parser_unit_test.sv -----
// stimulus, clock, reset and verdict for the frame parser unit
`timescale 1ns / 1ps
module dollar_star_frame_parser_unit_test;
  import dsfp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
  localparam int RANDOM_ITEMS = 1550;  // frame bytes in the random part
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off

  // shapes of frames the random part builds
  typedef enum int {
    FR_GOOD,      // $TYPE,PAYLOAD*
    FR_BARE,      // $TYPE*
    FR_TYPE_OVF,  // six type chars then a non-comma
    FR_PAY_OVF,   // full payload then a non-star
    FR_JUNK       // arbitrary bytes after the type, closed by a star
  } frame_kind_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              in_rx_byte;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_message_done;
  logic                    out_frame_error;
  logic [TYPE_CHARS_W-1:0] out_type_chars;
  logic [TYPE_LEN_W-1:0]   out_type_length;
  logic [PAY_LEN_W-1:0]    out_payload_length;
  logic [7:0]              out_payload_byte;
  logic                    out_payload_byte_valid;
  logic [PAY_LEN_W-1:0]    out_payload_index;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned frames_done;
  int unsigned frames_aborted;
  int unsigned payload_seen;

  // knobs and counts used by the sender and the receiver
  bit          no_gaps;
  bit          no_stalls;
  bit          hold_req;
  int unsigned driven_bytes;
  int unsigned frame_items;

  dollar_star_frame_parser_unit DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_message_done       (out_message_done),
    .out_frame_error        (out_frame_error),
    .out_type_chars         (out_type_chars),
    .out_type_length        (out_type_length),
    .out_payload_length     (out_payload_length),
    .out_payload_byte       (out_payload_byte),
    .out_payload_byte_valid (out_payload_byte_valid),
    .out_payload_index      (out_payload_index)
  );

  // predicts every result and compares it; failures come back as a count
  dsfp_result_check result_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_message_done       (out_message_done),
    .out_frame_error        (out_frame_error),
    .out_type_chars         (out_type_chars),
    .out_type_length        (out_type_length),
    .out_payload_length     (out_payload_length),
    .out_payload_byte       (out_payload_byte),
    .out_payload_byte_valid (out_payload_byte_valid),
    .out_payload_index      (out_payload_index),
    .mismatches             (mismatches),
    .pending                (pending),
    .frames_done            (frames_done),
    .frames_aborted         (frames_aborted),
    .payload_seen           (payload_seen)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random byte that is neither of two delimiters
  function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] x;
    do x = 8'($urandom_range(255)); while (x == a || x == c);
    return x;
  endfunction

  // one item on the input channel: optional idle gap, then hold until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    driven_bytes++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // body_len is the payload length, or the junk length for FR_JUNK
  task automatic send_frame(input frame_kind_t kind, input int tlen, input int body_len);
    int i;
    int unsigned start;
    start = driven_bytes;
    send_byte(CH_DOLLAR);
    for (i = 0; i < tlen; i++) send_byte(any_but(CH_COMMA, CH_STAR));
    case (kind)
      FR_BARE: send_byte(CH_STAR);
      // overflow byte is a star about half the time
      FR_TYPE_OVF: send_byte($urandom_range(1) ? CH_STAR : any_but(CH_COMMA, CH_COMMA));
      FR_JUNK: begin
        for (i = 0; i < body_len; i++) send_byte(8'($urandom_range(255)));
        // a star brings the parser back to hunt from any phase
        send_byte(CH_STAR);
      end
      default: begin
        send_byte(CH_COMMA);
        for (i = 0; i < body_len; i++) send_byte(any_but(CH_STAR, CH_STAR));
        send_byte(kind == FR_PAY_OVF ? any_but(CH_STAR, CH_STAR) : CH_STAR);
      end
    endcase
    frame_items += driven_bytes - start;
  endtask

  // receiver: random stall runs, a long hold-off on request
  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = HOLD_CYCLES;
          hold_req = 1'b0;
        end else if (!no_stalls && $urandom_range(99) < 40) begin
          stall_left = gap_len();
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long with no handshake on either channel ends the run
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
        idle++;
      else
        idle = 0;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int frame_no;
    int r;
    int tlen;
    int body_len;
    frame_kind_t kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    hold_req = 1'b0;
    driven_bytes = 0;
    frame_items = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // empty type, no payload
    send_byte(CH_DOLLAR);
    send_byte(CH_STAR);
    // comma form with an empty payload
    send_byte(CH_DOLLAR);
    send_text("AB");
    send_byte(CH_COMMA);
    send_byte(CH_STAR);
    // six type chars then a star: type overflow aborts
    send_byte(CH_DOLLAR);
    send_text("ABCDEF");
    send_byte(CH_STAR);
    // dollar inside type and payload is plain data, byte extremes as data
    send_byte(CH_DOLLAR);
    send_byte(8'hFF);
    send_byte(CH_DOLLAR);
    send_byte(CH_COMMA);
    send_byte(8'h00);
    send_byte(CH_DOLLAR);
    send_byte(CH_STAR);

    // random frames with some hunt noise between them
    frame_no = 0;
    while (frame_items < RANDOM_ITEMS) begin
      frame_no++;
      // every fourth run of six frames goes with no idling on either side
      no_gaps = ((frame_no / 6) % 4 == 1);
      no_stalls = no_gaps;
      if (frame_no % 45 == 20) drain();
      repeat ($urandom_range(0, 2)) send_byte(any_but(CH_DOLLAR, CH_DOLLAR));
      if (frame_no % 45 == 5) begin
        // receiver holds off while the sender streams at full rate
        hold_req = 1'b1;
        no_gaps = 1'b1;
        send_frame(FR_GOOD, TYPE_MAX_DEF, 40);
      end else begin
        r = $urandom_range(99);
        tlen = ($urandom_range(3) == 0) ? TYPE_MAX_DEF : $urandom_range(0, TYPE_MAX_DEF);
        if (r < 62) begin
          kind = FR_GOOD;
          r = $urandom_range(99);
          body_len = (r < 4) ? PAYLOAD_MAX_DEF : (r < 7) ? PAYLOAD_MAX_DEF - 1 :
                     $urandom_range(0, 20);
        end else if (r < 74) begin
          kind = FR_BARE;
          body_len = 0;
        end else if (r < 83) begin
          kind = FR_TYPE_OVF;
          tlen = TYPE_MAX_DEF;
          body_len = 0;
        end else if (r < 86) begin
          kind = FR_PAY_OVF;
          body_len = PAYLOAD_MAX_DEF;
        end else begin
          kind = FR_JUNK;
          body_len = $urandom_range(3, 12);
        end
        send_frame(kind, tlen, body_len);
      end
    end

    // let everything come out, then a few more cycles for the pipeline
    no_stalls = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    $display("run: %0d bytes driven over %0d random frames", driven_bytes, frame_no);
    $display("run: %0d frames completed, %0d aborted, %0d payload bytes streamed",
             frames_done, frames_aborted, payload_seen);
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dsfp_pkg.sv
rtl/dsfp_in_stage.sv
rtl/dsfp_parse.sv
rtl/dollar_star_frame_parser_unit.sv
rtl/dsfp_checker.sv
tb/dsfp_result_check.sv
tb/dollar_star_frame_parser_unit_test.sv
